### rtl/dsq_pkg.sv
// Shared constants and controller/datapath interface types for the dedup sorted queue.
package dsq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ID_WIDTH_DEF  = 8;
	localparam int KEY_WIDTH_DEF = 16;

	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic ORDER_FIFO   = 1'b0;
	localparam logic ORDER_SORTED = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request fields
		logic compare;  // evaluate per-cell match and order flags
		logic apply;    // update cells and load result register
	} dsq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_busy; // result register holds a transfer not yet taken
	} dsq_stat_t;

endpackage

### rtl/dsq_ctrl.sv
// Sequencing state machine for the dedup sorted queue.
module dsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dsq_pkg::dsq_stat_t stat,
	output dsq_pkg::dsq_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.compare = 1'b0;
		cmd.apply   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_APPLY;
			end
			S_APPLY: begin
				// hold until the result register is free
				if (!stat.rsp_busy) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/dsq_datapath.sv
// Cell array, per-cell comparators and result register of the dedup sorted queue.
module dsq_datapath #(
	parameter int DEPTH     = dsq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH  = dsq_pkg::ID_WIDTH_DEF,
	parameter int KEY_WIDTH = dsq_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsq_pkg::dsq_cmd_t             cmd,
	output dsq_pkg::dsq_stat_t            stat,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	input  logic                          mode,
	input  logic [ID_WIDTH-1:0]           task_id,
	input  logic [KEY_WIDTH-1:0]          prio_key,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [dsq_pkg::STATUS_W-1:0]  status,
	output logic [ID_WIDTH-1:0]           popped_id,
	output logic [KEY_WIDTH-1:0]          popped_key,
	output logic                          head_valid,
	output logic [ID_WIDTH-1:0]           head_id,
	output logic [KEY_WIDTH-1:0]          head_key,
	output logic                          is_empty
);

	localparam int FW = $clog2(DEPTH + 1);

	logic                 order_mode_q;
	logic                 op_q;
	logic [ID_WIDTH-1:0]  id_q;
	logic [KEY_WIDTH-1:0] key_q;

	logic [ID_WIDTH-1:0]  cell_id_q  [DEPTH];
	logic [KEY_WIDTH-1:0] cell_key_q [DEPTH];
	logic [ID_WIDTH-1:0]  cell_id_d  [DEPTH];
	logic [KEY_WIDTH-1:0] cell_key_d [DEPTH];
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        fill_d;

	logic [DEPTH-1:0] match_d;
	logic [DEPTH-1:0] lt_d;
	logic [DEPTH-1:0] match_q;
	logic [DEPTH-1:0] lt_q;     // entry stays ahead of the new one
	logic [DEPTH-1:0] ins_at;   // cell that takes the new entry

	logic dup;
	logic full;
	logic empty;
	logic push_ok;
	logic pop_ok;
	logic [dsq_pkg::STATUS_W-1:0] status_d;

	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= dsq_pkg::ORDER_SORTED;
		end else if (cfg_wen) begin
			order_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= mode;
			id_q  <= task_id;
			key_q <= prio_key;
		end
	end

	// per-cell compare; the ahead flag stops at the first cell that is not ahead,
	// so cells left over from FIFO order still give one insert point
	always_comb begin
		logic ahead;
		ahead = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			match_d[i] = (FW'(i) < fill_q) && (cell_id_q[i] == id_q);
			ahead      = ahead && (FW'(i) < fill_q) &&
				((order_mode_q == dsq_pkg::ORDER_FIFO) || (cell_key_q[i] < key_q));
			lt_d[i]    = ahead;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_q <= match_d;
			lt_q    <= lt_d;
		end
	end

	assign dup     = |match_q;
	assign full    = (fill_q == FW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign push_ok = (op_q == dsq_pkg::OP_PUSH) && !dup && !full;
	assign pop_ok  = (op_q == dsq_pkg::OP_POP) && !empty;
	assign ins_at  = ~lt_q & {lt_q[DEPTH-2:0], 1'b1};

	// next value of each cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_id_d[i]  = cell_id_q[i];
			cell_key_d[i] = cell_key_q[i];
			if (push_ok && ins_at[i]) begin
				cell_id_d[i]  = id_q;
				cell_key_d[i] = key_q;
			end else if (push_ok && !lt_q[i]) begin
				cell_id_d[i]  = cell_id_q[(i == 0) ? 0 : i-1];
				cell_key_d[i] = cell_key_q[(i == 0) ? 0 : i-1];
			end else if (pop_ok && i < DEPTH-1) begin
				cell_id_d[i]  = cell_id_q[(i < DEPTH-1) ? i+1 : i];
				cell_key_d[i] = cell_key_q[(i < DEPTH-1) ? i+1 : i];
			end
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (push_ok) begin
			fill_d = fill_q + FW'(1);
		end else if (pop_ok) begin
			fill_d = fill_q - FW'(1);
		end
	end

	always_comb begin
		if (op_q == dsq_pkg::OP_PUSH) begin
			if (dup) begin
				status_d = dsq_pkg::ST_DUPLICATE;
			end else if (full) begin
				status_d = dsq_pkg::ST_FULL;
			end else begin
				status_d = dsq_pkg::ST_PUSHED;
			end
		end else begin
			status_d = empty ? dsq_pkg::ST_EMPTY : dsq_pkg::ST_POPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.apply) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				cell_id_q[i]  <= cell_id_d[i];
				cell_key_q[i] <= cell_key_d[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status     <= status_d;
			popped_id  <= pop_ok ? cell_id_q[0]  : '0;
			popped_key <= pop_ok ? cell_key_q[0] : '0;
			head_valid <= (fill_d != '0);
			head_id    <= (fill_d != '0) ? cell_id_d[0]  : '0;
			head_key   <= (fill_d != '0) ? cell_key_d[0] : '0;
			is_empty   <= (fill_d == '0);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign stat.rsp_busy = rsp_valid_q && rsp_stall;

endmodule

### rtl/dedup_sorted_priority_queue_top.sv
// Top level of the dedup sorted priority queue: controller plus cell datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  request  | req_valid / req_stall    | mode, task_id, prio_key
//  response | rsp_valid / rsp_stall    | status, popped_id, popped_key, head_valid,
//           |                          | head_id, head_key, is_empty
//  config   | cfg_wen (no wait)        | cfg_wdata -> order_mode
//
// Each request goes through three steps: capture, per-cell compare (match and order
// flags registered in every cell), then apply, where the cell row shifts and the
// result register loads; req_stall holds the next request until apply is done.
// Reset (arst_n low) empties the queue and sets ascending key order; cell
// contents are not cleared, only the fill count.
// The next request is taken while a result waits; apply holds until the
// result register is free, so a stalled response never changes.
module dedup_sorted_priority_queue_top #(
	parameter int DEPTH     = dsq_pkg::DEPTH_DEF,
	parameter int ID_WIDTH  = dsq_pkg::ID_WIDTH_DEF,
	parameter int KEY_WIDTH = dsq_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          mode,
	input  logic [ID_WIDTH-1:0]           task_id,
	input  logic [KEY_WIDTH-1:0]          prio_key,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [dsq_pkg::STATUS_W-1:0]  status,
	output logic [ID_WIDTH-1:0]           popped_id,
	output logic [KEY_WIDTH-1:0]          popped_key,
	output logic                          head_valid,
	output logic [ID_WIDTH-1:0]           head_id,
	output logic [KEY_WIDTH-1:0]          head_key,
	output logic                          is_empty
);

	dsq_pkg::dsq_cmd_t  cmd;
	dsq_pkg::dsq_stat_t stat;

	dsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// cells, comparators and the response register
	dsq_datapath #(
		.DEPTH     (DEPTH),
		.ID_WIDTH  (ID_WIDTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.mode       (mode),
		.task_id    (task_id),
		.prio_key   (prio_key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.popped_id  (popped_id),
		.popped_key (popped_key),
		.head_valid (head_valid),
		.head_id    (head_id),
		.head_key   (head_key),
		.is_empty   (is_empty)
	);

endmodule
